// ===== hdl/text_quad_layout_unit_macros.svh =====
// Assertion macros used by the layout unit checker
`ifndef TEXT_QUAD_LAYOUT_UNIT_MACROS_SVH
`define TEXT_QUAD_LAYOUT_UNIT_MACROS_SVH

// same-cycle implication, disabled in reset
`define TQLU_ASSERT_IMM(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("%m: assertion failed");

// next-cycle implication, disabled in reset
`define TQLU_ASSERT_NXT(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("%m: assertion failed");

`endif

// ===== hdl/tqlu_pkg.sv =====
// Types and constants of the text quad layout unit
package tqlu_pkg;

  localparam int unsigned CHAR_W    = 21;
  localparam int unsigned OUT_W     = 16;
  localparam int unsigned TEX_W     = 13;
  localparam int unsigned EXT_W     = 15;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 9;

  localparam logic [CHAR_W-1:0] CH_NEWLINE = 21'd10;
  localparam logic [CHAR_W-1:0] CH_TAB     = 21'd9;

  localparam logic [2:0] LAST_VERT_IDX = 3'd5;
  localparam logic [2:0] SUMMARY_IDX   = 3'd6;
  // vertex order TL, BL, BR, TL, BR, TR
  localparam logic [7:0] RIGHT_MASK  = 8'b0011_0100;
  localparam logic [7:0] BOTTOM_MASK = 8'b0001_0110;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FONT_HEIGHT   = 2'd0,
    CFG_LINE_HEIGHT   = 2'd1,
    CFG_SPACE_ADVANCE = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic signed [OUT_W-1:0] x0;
    logic signed [OUT_W-1:0] x1;
    logic signed [OUT_W-1:0] y0;
    logic signed [OUT_W-1:0] y1;
    logic [TEX_W-1:0]        u0;
    logic [TEX_W-1:0]        u1;
    logic [TEX_W-1:0]        vt;
    logic [TEX_W-1:0]        vb;
    logic                    has_quad;
    logic                    has_sum;
    logic [EXT_W-1:0]        ext_w;
    logic [EXT_W-1:0]        ext_h;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage

// ===== hdl/text_quad_layout_unit.sv =====
// Text quad layout unit: top level joining front end, job queue and back end
// Path: a character enters the stage B register, then the job queue, then the output.
// Throughput: one word a cycle while the output is not stalled and a job is queued;
// a sized glyph gives six vertex words, plus a summary word for the last character.
// The two-entry job queue sets how far the front end may run ahead of the output.
// Reset: pen, bounds and queue clear, registers return to 16, 19 and 4.
module text_quad_layout_unit import tqlu_pkg::*; #(
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [CFG_DAT_W-1:0]    cfg_data_i,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [CHAR_W-1:0]       char_code_i,
  input  logic signed [7:0]       bearing_x_i,
  input  logic signed [8:0]       bearing_y_i,
  input  logic [7:0]              glyph_width_i,
  input  logic [7:0]              glyph_height_i,
  input  logic [11:0]             atlas_x_i,
  input  logic [11:0]             atlas_y_i,
  input  logic [7:0]              advance_i,
  input  logic                    last_char_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic signed [OUT_W-1:0] pos_x_o,
  output logic signed [OUT_W-1:0] pos_y_o,
  output logic [TEX_W-1:0]        tex_u_o,
  output logic [TEX_W-1:0]        tex_v_o,
  output logic                    is_summary_o,
  output logic [EXT_W-1:0]        extent_w_o,
  output logic [EXT_W-1:0]        extent_h_o,
  output logic                    last_of_run_o
);

  job_t       job, head;
  fifo_stat_t stat;
  logic       push, pop;

  tqlu_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i,
    .in_valid_i,
    .in_stall_o,
    .char_code_i,
    .bearing_x_i,
    .bearing_y_i,
    .glyph_width_i,
    .glyph_height_i,
    .atlas_x_i,
    .atlas_y_i,
    .advance_i,
    .last_char_i,
    .fifo_stat_i (stat),
    .push_o      (push),
    .job_o       (job)
  );

  tqlu_fifo u_fifo (
    .clk_i,
    .rst_ni,
    .push_i (push),
    .job_i  (job),
    .pop_i  (pop),
    .head_o (head),
    .stat_o (stat)
  );

  tqlu_back u_back (
    .clk_i,
    .rst_ni,
    .head_i      (head),
    .fifo_stat_i (stat),
    .pop_o       (pop),
    .out_valid_o,
    .out_stall_i,
    .pos_x_o,
    .pos_y_o,
    .tex_u_o,
    .tex_v_o,
    .is_summary_o,
    .extent_w_o,
    .extent_h_o,
    .last_of_run_o
  );

endmodule

// ===== hdl/tqlu_front.sv =====
// Front end: pen tracking, quad corners, bounds and job issue
module tqlu_front import tqlu_pkg::*; #(
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_DAT_W-1:0] cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [CHAR_W-1:0]    char_code_i,
  input  logic signed [7:0]    bearing_x_i,
  input  logic signed [8:0]    bearing_y_i,
  input  logic [7:0]           glyph_width_i,
  input  logic [7:0]           glyph_height_i,
  input  logic [11:0]          atlas_x_i,
  input  logic [11:0]          atlas_y_i,
  input  logic [7:0]           advance_i,
  input  logic                 last_char_i,
  input  fifo_stat_t           fifo_stat_i,
  output logic                 push_o,
  output job_t                 job_o
);

  localparam int unsigned C = COORD_BITS;

  typedef logic signed [C-1:0] coord_t;
  typedef logic signed [C:0]   wide_t;

  function automatic coord_t sat_c(input wide_t v);
    if (v[C] != v[C-1]) begin
      return v[C] ? {1'b1, {(C-1){1'b0}}} : {1'b0, {(C-1){1'b1}}};
    end
    return v[C-1:0];
  endfunction

  function automatic logic signed [33:0] ext34(input coord_t v);
    return {{(34-C){v[C-1]}}, v};
  endfunction

  function automatic logic [OUT_W-1:0] out16(input coord_t v);
    logic signed [33:0] e;
    e = ext34(v);
    if (e > 34'sd32767) return 16'h7fff;
    if (e < -34'sd32768) return 16'h8000;
    return e[OUT_W-1:0];
  endfunction

  function automatic logic [EXT_W-1:0] ext15(input logic signed [33:0] e);
    if (e > 34'sd32767) return 15'h7fff;
    if (e < 34'sd0) return '0;
    return e[EXT_W-1:0];
  endfunction

  logic [7:0] font_height_q;
  logic [8:0] line_height_q;
  logic [7:0] space_adv_q;

  coord_t pen_x_q, pen_x_d, pen_y_q, pen_y_d;
  coord_t max_q, max_d, min_q, min_d;
  logic   start_q;

  // stage B holding register
  logic        b_valid_q, b_valid_d;
  coord_t      b_x0_q, b_y0_q;
  logic [7:0]  b_gw_q, b_gh_q;
  logic [11:0] b_ax_q, b_ay_q;
  logic        b_quad_q, b_last_q, b_first_q;

  logic   acc, is_nl, is_tab, quad_a, b_need, b_go;
  coord_t px_base, py_base, x0_a, y0_a, x1_b, y1_b, max_base, min_base;
  logic signed [33:0] neg_min;

  assign is_nl  = (char_code_i == CH_NEWLINE);
  assign is_tab = (char_code_i == CH_TAB);
  assign quad_a = !is_nl && !is_tab && (glyph_width_i != 8'd0) && (glyph_height_i != 8'd0);

  assign b_need     = b_quad_q || b_last_q;
  assign b_go       = b_valid_q && (!b_need || !fifo_stat_i.full);
  assign in_stall_o = b_valid_q && b_need && fifo_stat_i.full;
  assign acc        = in_valid_i && !in_stall_o;
  assign push_o     = b_valid_q && b_need && !fifo_stat_i.full;

  always_comb begin
    px_base = start_q ? '0 : pen_x_q;
    py_base = start_q ? coord_t'({C{1'b0}} - {{(C-8){1'b0}}, font_height_q}) : pen_y_q;
    x0_a = sat_c(wide_t'({px_base[C-1], px_base}) + {{(C+1-8){bearing_x_i[7]}}, bearing_x_i});
    y0_a = sat_c(wide_t'({py_base[C-1], py_base}) + {{(C+1-9){bearing_y_i[8]}}, bearing_y_i});
    pen_x_d = pen_x_q;
    pen_y_d = pen_y_q;
    if (acc) begin
      pen_y_d = py_base;
      if (is_nl) begin
        pen_x_d = '0;
        pen_y_d = sat_c(wide_t'({py_base[C-1], py_base}) - {{(C+1-9){1'b0}}, line_height_q});
      end else if (is_tab) begin
        pen_x_d = sat_c(wide_t'({px_base[C-1], px_base})
                        + {{(C+1-10){1'b0}}, space_adv_q, 2'b00});
      end else begin
        pen_x_d = sat_c(wide_t'({px_base[C-1], px_base}) + {{(C+1-8){1'b0}}, advance_i});
      end
    end
    b_valid_d = acc ? 1'b1 : (b_go ? 1'b0 : b_valid_q);
  end

  always_comb begin
    x1_b = sat_c(wide_t'({b_x0_q[C-1], b_x0_q}) + {{(C+1-8){1'b0}}, b_gw_q});
    y1_b = sat_c(wide_t'({b_y0_q[C-1], b_y0_q}) - {{(C+1-8){1'b0}}, b_gh_q});
    max_base = b_first_q ? '0 : max_q;
    min_base = b_first_q ? '0 : min_q;
    max_d = (b_quad_q && (x1_b > max_base)) ? x1_b : max_base;
    min_d = (b_quad_q && (y1_b < min_base)) ? y1_b : min_base;
    neg_min = 34'sd0 - ext34(min_d);
    job_o.x0       = out16(b_x0_q);
    job_o.x1       = out16(x1_b);
    job_o.y0       = out16(b_y0_q);
    job_o.y1       = out16(y1_b);
    job_o.u0       = {1'b0, b_ax_q};
    job_o.u1       = {1'b0, b_ax_q} + {5'd0, b_gw_q};
    job_o.vt       = {1'b0, b_ay_q} + {5'd0, b_gh_q};
    job_o.vb       = {1'b0, b_ay_q};
    job_o.has_quad = b_quad_q;
    job_o.has_sum  = b_last_q;
    job_o.ext_w    = ext15(ext34(max_d));
    job_o.ext_h    = ext15(neg_min);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      font_height_q <= 8'd16;
      line_height_q <= 9'd19;
      space_adv_q   <= 8'd4;
      pen_x_q       <= '0;
      pen_y_q       <= '0;
      max_q         <= '0;
      min_q         <= '0;
      start_q       <= 1'b1;
      b_valid_q     <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_FONT_HEIGHT:   font_height_q <= cfg_data_i[7:0];
          CFG_LINE_HEIGHT:   line_height_q <= cfg_data_i;
          CFG_SPACE_ADVANCE: space_adv_q   <= cfg_data_i[7:0];
          default: ;
        endcase
      end
      pen_x_q   <= pen_x_d;
      pen_y_q   <= pen_y_d;
      b_valid_q <= b_valid_d;
      if (acc) begin
        start_q <= last_char_i;
      end
      if (b_go) begin
        max_q <= max_d;
        min_q <= min_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      b_x0_q    <= x0_a;
      b_y0_q    <= y0_a;
      b_gw_q    <= glyph_width_i;
      b_gh_q    <= glyph_height_i;
      b_ax_q    <= atlas_x_i;
      b_ay_q    <= atlas_y_i;
      b_quad_q  <= quad_a;
      b_last_q  <= last_char_i;
      b_first_q <= start_q;
    end
  end

endmodule

// ===== hdl/tqlu_fifo.sv =====
// Two-entry job queue between front and back end
module tqlu_fifo import tqlu_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  job_t       job_i,
  input  logic       pop_i,
  output job_t       head_o,
  output fifo_stat_t stat_o
);

  job_t       mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;

  assign head_o       = mem_q[rd_ptr_q];
  assign stat_o.full  = (count_q == 2'd2);
  assign stat_o.empty = (count_q == 2'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

endmodule

// ===== hdl/tqlu_back.sv =====
// Back end: expands a job into vertex and summary words
module tqlu_back import tqlu_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  job_t                    head_i,
  input  fifo_stat_t              fifo_stat_i,
  output logic                    pop_o,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic signed [OUT_W-1:0] pos_x_o,
  output logic signed [OUT_W-1:0] pos_y_o,
  output logic [TEX_W-1:0]        tex_u_o,
  output logic [TEX_W-1:0]        tex_v_o,
  output logic                    is_summary_o,
  output logic [EXT_W-1:0]        extent_w_o,
  output logic [EXT_W-1:0]        extent_h_o,
  output logic                    last_of_run_o
);

  logic [2:0] idx_q;
  logic       load, emit, cur_sum, fin, right, bottom;

  assign load    = !out_valid_o || !out_stall_i;
  assign emit    = load && !fifo_stat_i.empty;
  assign cur_sum = !head_i.has_quad || (idx_q == SUMMARY_IDX);
  assign fin     = cur_sum || ((idx_q == LAST_VERT_IDX) && !head_i.has_sum);
  assign right   = RIGHT_MASK[idx_q];
  assign bottom  = BOTTOM_MASK[idx_q];
  assign pop_o   = emit && fin;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_o <= 1'b0;
    end else begin
      if (load) begin
        out_valid_o <= !fifo_stat_i.empty;
      end
      if (emit) begin
        idx_q <= fin ? 3'd0 : idx_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      last_of_run_o <= fin;
      is_summary_o  <= cur_sum;
      if (cur_sum) begin
        pos_x_o    <= '0;
        pos_y_o    <= '0;
        tex_u_o    <= '0;
        tex_v_o    <= '0;
        extent_w_o <= head_i.ext_w;
        extent_h_o <= head_i.ext_h;
      end else begin
        pos_x_o    <= right  ? head_i.x1 : head_i.x0;
        pos_y_o    <= bottom ? head_i.y1 : head_i.y0;
        tex_u_o    <= right  ? head_i.u1 : head_i.u0;
        tex_v_o    <= bottom ? head_i.vb : head_i.vt;
        extent_w_o <= '0;
        extent_h_o <= '0;
      end
    end
  end

endmodule

// ===== hdl/tqlu_checker.sv =====
// Port checker for the text quad layout unit and its bind
`include "text_quad_layout_unit_macros.svh"

module tqlu_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [15:0] pos_x_o,
  input logic [15:0] pos_y_o,
  input logic [12:0] tex_u_o,
  input logic [12:0] tex_v_o,
  input logic        is_summary_o,
  input logic [14:0] extent_w_o,
  input logic [14:0] extent_h_o,
  input logic        last_of_run_o
);

  `TQLU_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(pos_x_o) && $stable(pos_y_o) && $stable(last_of_run_o))
  `TQLU_ASSERT_IMM(a_sum_closes, clk_i, rst_ni, out_valid_o && is_summary_o, last_of_run_o && pos_x_o == 16'd0 && pos_y_o == 16'd0 && tex_u_o == 13'd0 && tex_v_o == 13'd0)
  `TQLU_ASSERT_IMM(a_vert_no_ext, clk_i, rst_ni, out_valid_o && !is_summary_o, extent_w_o == 15'd0 && extent_h_o == 15'd0)
  `TQLU_ASSERT_NXT(a_run_gapless, clk_i, rst_ni, out_valid_o && !out_stall_i && !last_of_run_o, out_valid_o)

endmodule

bind text_quad_layout_unit tqlu_checker u_tqlu_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .pos_x_o       (pos_x_o),
  .pos_y_o       (pos_y_o),
  .tex_u_o       (tex_u_o),
  .tex_v_o       (tex_v_o),
  .is_summary_o  (is_summary_o),
  .extent_w_o    (extent_w_o),
  .extent_h_o    (extent_h_o),
  .last_of_run_o (last_of_run_o)
);

// ===== test/text_quad_layout_unit_test.sv =====
// Self-checking testbench for the text quad layout unit: directed table, then random strings
`timescale 1ns / 100ps

module text_quad_layout_unit_test;
  import tqlu_pkg::*;

  localparam int CLK_PERIOD    = 4;
  localparam int RESET_CYCLES  = 6;
  localparam int SETTLE_CYCLES = 20;
  localparam int END_CYCLES    = 20;
  localparam int STALL_LIMIT   = 2000;
  localparam int TAB_SPACES    = 4;
  localparam int N_PHASES      = 9;
  localparam int N_DIRECTED    = 15;
  localparam int MAX_PRINTS    = 40;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;

  typedef struct packed {
    logic [CHAR_W-1:0] code;
    logic signed [7:0] bx;
    logic signed [8:0] by;
    logic [7:0]        gw;
    logic [7:0]        gh;
    logic [11:0]       ax;
    logic [11:0]       ay;
    logic [7:0]        adv;
    logic              last;
  } char_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] pos_x;
    logic signed [OUT_W-1:0] pos_y;
    logic [TEX_W-1:0]        tex_u;
    logic [TEX_W-1:0]        tex_v;
    logic                    is_summary;
    logic [EXT_W-1:0]        extent_w;
    logic [EXT_W-1:0]        extent_h;
    logic                    last_of_run;
  } word_t;

  typedef struct packed {
    char_t            c;
    logic             typed;
    logic [EXT_W-1:0] ew;
    logic [EXT_W-1:0] eh;
  } dir_row_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_idx_i = '0;
  logic [CFG_DAT_W-1:0]    cfg_data_i = '0;
  logic                    in_valid_i = 1'b0;
  logic                    in_stall_o;
  logic [CHAR_W-1:0]       char_code_i = '0;
  logic signed [7:0]       bearing_x_i = '0;
  logic signed [8:0]       bearing_y_i = '0;
  logic [7:0]              glyph_width_i = '0;
  logic [7:0]              glyph_height_i = '0;
  logic [11:0]             atlas_x_i = '0;
  logic [11:0]             atlas_y_i = '0;
  logic [7:0]              advance_i = '0;
  logic                    last_char_i = 1'b0;
  logic                    out_valid_o;
  logic                    out_stall_i = 1'b0;
  logic signed [OUT_W-1:0] pos_x_o;
  logic signed [OUT_W-1:0] pos_y_o;
  logic [TEX_W-1:0]        tex_u_o;
  logic [TEX_W-1:0]        tex_v_o;
  logic                    is_summary_o;
  logic [EXT_W-1:0]        extent_w_o;
  logic [EXT_W-1:0]        extent_h_o;
  logic                    last_of_run_o;

  // layout state mirrored from the block
  logic [7:0] reg_font_h = 8'd16;
  logic [8:0] reg_line_h = 9'd19;
  logic [7:0] reg_space  = 8'd4;
  int         cur_x = 0;
  int         cur_y = 0;
  int         right_max = 0;
  int         bottom_min = 0;
  logic       new_string = 1'b1;

  word_t vertex_q[$];
  int    n_mismatch = 0;
  int    calm_in = 0;
  int    calm_out = 0;
  int    stall_left = 0;

  dir_row_t dir_tab [N_DIRECTED] = '{
    '{'{21'd0, 8'sd0, 9'sd0, 8'd0, 8'd0, 12'd0, 12'd0, 8'd0, 1'b1}, 1'b1, 15'd0, 15'd0},
    '{'{21'd65, 8'sd0, 9'sd0, 8'd10, 8'd10, 12'd0, 12'd0, 8'd12, 1'b0}, 1'b0, 15'd0, 15'd0},
    '{'{CH_NEWLINE, 8'sd0, 9'sd0, 8'd0, 8'd0, 12'd0, 12'd0, 8'd0, 1'b1}, 1'b1, 15'd10, 15'd26},
    '{'{CH_TAB, 8'sd5, 9'sd3, 8'd7, 8'd7, 12'd1, 12'd2, 8'd9, 1'b0}, 1'b0, 15'd0, 15'd0},
    '{'{21'h1FFFFF, 8'h80, 9'h100, 8'd255, 8'd255, 12'hFFF, 12'hFFF, 8'd255, 1'b0},
      1'b0, 15'd0, 15'd0},
    '{'{21'd66, 8'sd127, 9'sd255, 8'd1, 8'd1, 12'd0, 12'd0, 8'd0, 1'b0}, 1'b0, 15'd0, 15'd0},
    '{'{21'd67, -8'sd1, -9'sd1, 8'd0, 8'd255, 12'd100, 12'd200, 8'd7, 1'b0},
      1'b0, 15'd0, 15'd0},
    '{'{21'd68, 8'sd0, 9'sd0, 8'd255, 8'd0, 12'hAAA, 12'h555, 8'd3, 1'b0}, 1'b0, 15'd0, 15'd0},
    '{'{CH_NEWLINE, -8'sd5, 9'sd17, 8'd40, 8'd40, 12'd9, 12'd9, 8'd200, 1'b0},
      1'b0, 15'd0, 15'd0},
    '{'{21'd11, 8'sd2, -9'sd3, 8'd5, 8'd6, 12'h555, 12'hAAA, 8'd128, 1'b0},
      1'b0, 15'd0, 15'd0},
    '{'{21'd8, -8'sd7, 9'sd40, 8'd12, 8'd3, 12'd77, 12'd4000, 8'd15, 1'b0}, 1'b0, 15'd0, 15'd0},
    '{'{21'd32, 8'sd0, 9'sd0, 8'd0, 8'd0, 12'd0, 12'd0, 8'd255, 1'b0}, 1'b0, 15'd0, 15'd0},
    '{'{21'd90, 8'sd3, 9'sd10, 8'd20, 8'd30, 12'd4000, 12'd4000, 8'd30, 1'b1},
      1'b0, 15'd0, 15'd0},
    '{'{CH_TAB, 8'sd0, 9'sd0, 8'd0, 8'd0, 12'd0, 12'd0, 8'd0, 1'b1}, 1'b1, 15'd0, 15'd0},
    '{'{21'h10000A, 8'sd1, 9'sd1, 8'd9, 8'd9, 12'd5, 12'd6, 8'd10, 1'b1}, 1'b0, 15'd0, 15'd0}
  };

  text_quad_layout_unit u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .char_code_i    (char_code_i),
    .bearing_x_i    (bearing_x_i),
    .bearing_y_i    (bearing_y_i),
    .glyph_width_i  (glyph_width_i),
    .glyph_height_i (glyph_height_i),
    .atlas_x_i      (atlas_x_i),
    .atlas_y_i      (atlas_y_i),
    .advance_i      (advance_i),
    .last_char_i    (last_char_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .pos_x_o        (pos_x_o),
    .pos_y_o        (pos_y_o),
    .tex_u_o        (tex_u_o),
    .tex_v_o        (tex_v_o),
    .is_summary_o   (is_summary_o),
    .extent_w_o     (extent_w_o),
    .extent_h_o     (extent_h_o),
    .last_of_run_o  (last_of_run_o)
  );

  always #(CLK_PERIOD / 2.0) clk_i = ~clk_i;

  function automatic int clip16(int v);
    if (v < -32768) return -32768;
    if (v > 32767) return 32767;
    return v;
  endfunction

  function automatic logic [EXT_W-1:0] clip_extent(int v);
    if (v < 0) return '0;
    if (v > 32767) return 15'd32767;
    return v[EXT_W-1:0];
  endfunction

  function automatic word_t mk_vertex(int x, int y, logic [TEX_W-1:0] u, logic [TEX_W-1:0] v);
    word_t w;
    w = '0;
    w.pos_x = x[OUT_W-1:0];
    w.pos_y = y[OUT_W-1:0];
    w.tex_u = u;
    w.tex_v = v;
    return w;
  endfunction

  function automatic word_t mk_summary(logic [EXT_W-1:0] ew, logic [EXT_W-1:0] eh);
    word_t w;
    w = '0;
    w.is_summary  = 1'b1;
    w.extent_w    = ew;
    w.extent_h    = eh;
    w.last_of_run = 1'b1;
    return w;
  endfunction

  task automatic lay_out_char(input char_t c);
    int               x0, x1, y0, y1, n;
    logic [TEX_W-1:0] u0, u1, vt, vb;
    word_t            run [7];
    n = 0;
    if (new_string) begin
      cur_x      = 0;
      cur_y      = clip16(-int'(reg_font_h));
      right_max  = 0;
      bottom_min = 0;
      new_string = 1'b0;
    end
    if (c.code == CH_NEWLINE) begin
      cur_x = 0;
      cur_y = clip16(cur_y - int'(reg_line_h));
    end else if (c.code == CH_TAB) begin
      cur_x = clip16(cur_x + TAB_SPACES * int'(reg_space));
    end else begin
      if (c.gw != 0 && c.gh != 0) begin
        x0 = clip16(cur_x + int'(c.bx));
        x1 = clip16(x0 + int'(c.gw));
        y0 = clip16(cur_y + int'(c.by));
        y1 = clip16(y0 - int'(c.gh));
        u0 = {1'b0, c.ax};
        u1 = {1'b0, c.ax} + c.gw;
        vt = {1'b0, c.ay} + c.gh;
        vb = {1'b0, c.ay};
        if (x1 > right_max) right_max = x1;
        if (y1 < bottom_min) bottom_min = y1;
        run[0] = mk_vertex(x0, y0, u0, vt);
        run[1] = mk_vertex(x0, y1, u0, vb);
        run[2] = mk_vertex(x1, y1, u1, vb);
        run[3] = mk_vertex(x0, y0, u0, vt);
        run[4] = mk_vertex(x1, y1, u1, vb);
        run[5] = mk_vertex(x1, y0, u1, vt);
        n = 6;
      end
      cur_x = clip16(cur_x + int'(c.adv));
    end
    if (c.last) begin
      run[n] = mk_summary(clip_extent(right_max), clip_extent(-bottom_min));
      n++;
      new_string = 1'b1;
    end
    if (n > 0) run[n-1].last_of_run = 1'b1;
    for (int i = 0; i < n; i++) vertex_q.push_back(run[i]);
  endtask

  function automatic int pick_gap();
    int r;
    if (calm_in > 0) begin
      calm_in--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 4) begin
      calm_in = $urandom_range(20, 50);
      return 0;
    end
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic char_t random_char();
    char_t c;
    int    kind;
    c.code = CHAR_W'($urandom);
    c.bx   = 8'($urandom);
    c.by   = 9'($urandom);
    c.gw   = 8'($urandom_range(1, 255));
    c.gh   = 8'($urandom_range(1, 255));
    c.ax   = 12'($urandom);
    c.ay   = 12'($urandom);
    c.adv  = 8'($urandom);
    c.last = ($urandom_range(0, 7) == 0);
    kind   = $urandom_range(0, 99);
    if (kind < 50) begin
      if ($urandom_range(0, 1) == 1) c.code = CHAR_W'($urandom_range(32, 126));
    end else if (kind < 60) begin
      if ($urandom_range(0, 1) == 1) c.gw = '0;
      else c.gh = '0;
    end else if (kind < 64) begin
      c.gw = '0;
      c.gh = '0;
    end else if (kind < 76) begin
      c.code = CH_TAB;
    end else if (kind < 88) begin
      c.code = CH_NEWLINE;
    end else begin
      c.gw = ($urandom_range(0, 1) == 1) ? 8'd255 : 8'd1;
      c.gh = ($urandom_range(0, 1) == 1) ? 8'd255 : 8'd1;
      c.bx = ($urandom_range(0, 1) == 1) ? 8'h80 : 8'h7F;
      c.by = ($urandom_range(0, 1) == 1) ? 9'h100 : 9'h0FF;
    end
    return c;
  endfunction

  task automatic send_char(input char_t c);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk_i) in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    char_code_i    <= c.code;
    bearing_x_i    <= c.bx;
    bearing_y_i    <= c.by;
    glyph_width_i  <= c.gw;
    glyph_height_i <= c.gh;
    atlas_x_i      <= c.ax;
    atlas_y_i      <= c.ay;
    advance_i      <= c.adv;
    last_char_i    <= c.last;
    in_valid_i     <= 1'b1;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    lay_out_char(c);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    case (idx)
      CFG_FONT_HEIGHT:   reg_font_h = data[7:0];
      CFG_LINE_HEIGHT:   reg_line_h = data[8:0];
      CFG_SPACE_ADVANCE: reg_space  = data[7:0];
      default: ;
    endcase
  endtask

  task automatic set_layout_regs(input logic [CFG_DAT_W-1:0] fh, lh, sa);
    @(negedge clk_i) in_valid_i <= 1'b0;
    while (vertex_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    write_reg(CFG_FONT_HEIGHT, fh);
    write_reg(CFG_LINE_HEIGHT, lh);
    write_reg(CFG_SPACE_ADVANCE, sa);
    write_reg(CFG_UNUSED_IDX, CFG_DAT_W'($urandom));
    @(negedge clk_i) cfg_we_i <= 1'b0;
  endtask

  task automatic report_mismatch(input string what);
    if (n_mismatch < MAX_PRINTS) $display("mismatch at %0t: %s", $time, what);
    n_mismatch++;
  endtask

  always @(negedge clk_i) begin : drive_out_stall
    int r;
    if (stall_left > 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else if (calm_out > 0) begin
      calm_out--;
      out_stall_i <= 1'b0;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 3) calm_out = $urandom_range(30, 80);
      else if (r < 60) stall_left = 0;
      else if (r < 88) stall_left = $urandom_range(1, 3);
      else if (r < 98) stall_left = $urandom_range(4, 12);
      else stall_left = $urandom_range(20, 60);
      if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin : check_words
    word_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (vertex_q.size() == 0) begin
        report_mismatch("word with nothing expected");
      end else begin
        want = vertex_q.pop_front();
        if (pos_x_o !== want.pos_x)
          report_mismatch($sformatf("pos_x %0d, want %0d", pos_x_o, want.pos_x));
        if (pos_y_o !== want.pos_y)
          report_mismatch($sformatf("pos_y %0d, want %0d", pos_y_o, want.pos_y));
        if (tex_u_o !== want.tex_u)
          report_mismatch($sformatf("tex_u %0d, want %0d", tex_u_o, want.tex_u));
        if (tex_v_o !== want.tex_v)
          report_mismatch($sformatf("tex_v %0d, want %0d", tex_v_o, want.tex_v));
        if (is_summary_o !== want.is_summary)
          report_mismatch($sformatf("is_summary %0b, want %0b", is_summary_o, want.is_summary));
        if (extent_w_o !== want.extent_w)
          report_mismatch($sformatf("extent_w %0d, want %0d", extent_w_o, want.extent_w));
        if (extent_h_o !== want.extent_h)
          report_mismatch($sformatf("extent_h %0d, want %0d", extent_h_o, want.extent_h));
        if (last_of_run_o !== want.last_of_run)
          report_mismatch($sformatf("last_of_run %0b, want %0b", last_of_run_o,
                                    want.last_of_run));
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet = 0;
      else quiet++;
    end
    $display("FAILURE");
    $finish;
  end

  initial begin : stimulus
    char_t c;
    int    n_items;
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    for (int i = 0; i < N_DIRECTED; i++) begin
      send_char(dir_tab[i].c);
      if (dir_tab[i].typed) begin
        void'(vertex_q.pop_back());
        vertex_q.push_back(mk_summary(dir_tab[i].ew, dir_tab[i].eh));
      end
    end

    for (int p = 0; p < N_PHASES; p++) begin
      case (p)
        0: set_layout_regs(9'd255, 9'd511, 9'd255);
        1: set_layout_regs(9'd0, 9'd0, 9'd0);
        2: set_layout_regs(9'd1, 9'd1, 9'd0);
        default: set_layout_regs(CFG_DAT_W'($urandom), CFG_DAT_W'($urandom),
                                 CFG_DAT_W'($urandom));
      endcase
      if (p == 0) begin
        // drive the pen into saturation on both axes, then close with a huge glyph
        for (int i = 0; i < 98; i++) begin
          c      = random_char();
          c.code = (i < 64) ? CH_NEWLINE : CH_TAB;
          c.last = 1'b0;
          send_char(c);
        end
        c      = random_char();
        c.code = CHAR_W'(21'd77);
        c.bx   = 8'h7F;
        c.by   = 9'h100;
        c.gw   = 8'd255;
        c.gh   = 8'd255;
        c.last = 1'b1;
        send_char(c);
      end
      n_items = (p < 3) ? 14 : 36;
      for (int i = 0; i < n_items; i++) begin
        c = random_char();
        if (i == n_items - 1) c.last = 1'b1;
        send_char(c);
      end
    end

    @(negedge clk_i) in_valid_i <= 1'b0;
    while (vertex_q.size() != 0) @(posedge clk_i);
    repeat (END_CYCLES) @(posedge clk_i);
    if (n_mismatch == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
